### hdl/gkf_pkg.sv
package gkf_pkg;

  localparam int IDX_W   = 10;
  localparam int SIZE_W  = 11;
  localparam int COEF_W  = 32;
  localparam int DATA_W  = 32;
  localparam int SQ_W    = 2 * IDX_W;
  localparam int PROD_W  = COEF_W + SQ_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int EXPO_W  = 28;
  localparam int FRAC_W  = 24;
  localparam int EXP_W   = 31;
  localparam int Q_FRAC  = 30;
  localparam int GAIN_W  = 17;
  localparam int GAIN_SH = Q_FRAC - 16;

  // Clock edges from an accepted request to its result strobe.
  localparam int LATENCY = 11;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_Z = 3'd4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);

  // The gain is zero once the exponent reaches 12.0 in Q30.24.
  localparam logic [SUM_W-1:0] EXP_LIMIT = SUM_W'(64'd12 << FRAC_W);
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << 16;

  localparam logic [63:0] ONE48 = 64'd1 << 48;
  localparam int SERIES_TERMS = 20;
  localparam logic [63:0] FACT [0:20] = '{
    64'd1, 64'd1, 64'd2, 64'd6, 64'd24, 64'd120, 64'd720, 64'd5040, 64'd40320,
    64'd362880, 64'd3628800, 64'd39916800, 64'd479001600, 64'd6227020800,
    64'd87178291200, 64'd1307674368000, 64'd20922789888000,
    64'd355687428096000, 64'd6402373705728000, 64'd121645100408832000,
    64'd2432902008176640000
  };

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [COEF_W-1:0] coef_x;
    logic [COEF_W-1:0] coef_y;
    logic [COEF_W-1:0] coef_z;
  } cfg_t;

  typedef struct packed {
    logic              neg_re;
    logic [DATA_W-1:0] mag_re;
    logic              neg_im;
    logic [DATA_W-1:0] mag_im;
  } parts_t;

  typedef struct packed {
    logic              valid;
    logic              sat;
    logic [EXPO_W-1:0] a;
  } expo_t;

  typedef struct packed {
    logic              valid;
    logic [GAIN_W-1:0] gain;
  } gain_t;

  // exp(-x) for x in [0, 1] as Q16.48, by Taylor series. Evaluated only
  // while the gain tables are built.
  function automatic logic [63:0] exp_neg_q48(input logic [63:0] x);
    logic [127:0] pw;
    logic [63:0]  pos;
    logic [63:0]  neg;
    pos = ONE48;
    neg = '0;
    pw  = 128'(ONE48);
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      pw = (pw * 128'(x)) >> 48;
      if (k[0]) begin
        neg = neg + 64'(pw / 128'(FACT[k]));
      end else begin
        pos = pos + 64'(pw / 128'(FACT[k]));
      end
    end
    return pos - neg;
  endfunction

  function automatic logic [EXP_W-1:0] q48_to_q30(input logic [63:0] v);
    logic [63:0] r;
    r = (v + (64'd1 << 17)) >> 18;
    return EXP_W'(r);
  endfunction

  function automatic logic [EXP_W-1:0] exp_frac_q30(input logic [63:0] x_q48);
    return q48_to_q30(exp_neg_q48(x_q48));
  endfunction

  // exp(-n) for an integer n below 16, in Q1.30.
  function automatic logic [EXP_W-1:0] exp_int_q30(input int n);
    logic [63:0]  e1;
    logic [63:0]  v;
    logic [127:0] p;
    e1 = exp_neg_q48(ONE48);
    v  = ONE48;
    for (int i = 0; i < 16; i++) begin
      if (i < n) begin
        p = 128'(v) * 128'(e1) + (128'd1 << 47);
        v = 64'(p >> 48);
      end
    end
    return q48_to_q30(v);
  endfunction

endpackage

### hdl/gkf_exponent.sv
module gkf_exponent (
  input  logic                        clk,
  input  logic                        rst,
  input  gkf_pkg::cfg_t               cfg,
  input  logic                        valid_in,
  input  logic [gkf_pkg::IDX_W-1:0]   x_index,
  input  logic [gkf_pkg::IDX_W-1:0]   y_index,
  input  logic [gkf_pkg::IDX_W-1:0]   z_index,
  input  logic [gkf_pkg::DATA_W-1:0]  re_in,
  input  logic [gkf_pkg::DATA_W-1:0]  im_in,
  output gkf_pkg::expo_t              expo_out,
  output gkf_pkg::parts_t             parts_out
);
  import gkf_pkg::*;

  // Distance to the nearest zero frequency along a folded axis.
  function automatic logic [IDX_W-1:0] fold(input logic [IDX_W-1:0] idx,
                                            input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] wide;
    wide = SIZE_W'(idx);
    if (wide <= (size >> 1)) begin
      return idx;
    end else if (wide >= size) begin
      return IDX_W'(wide - size);
    end else begin
      return IDX_W'(size - wide);
    end
  endfunction

  logic [2:0] valid_q;

  logic [IDX_W-1:0]  fx, fy, fz;
  logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
  logic [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic [SUM_W-1:0]  sum;
  parts_t            parts_q [3];
  parts_t            parts_new;

  logic              expo_valid;
  logic              expo_sat;
  logic [EXPO_W-1:0] expo_a;

  always_comb begin
    parts_new.neg_re = re_in[DATA_W-1];
    parts_new.mag_re = re_in[DATA_W-1] ? (~re_in + DATA_W'(1)) : re_in;
    parts_new.neg_im = im_in[DATA_W-1];
    parts_new.mag_im = im_in[DATA_W-1] ? (~im_in + DATA_W'(1)) : im_in;
  end

  assign sum = SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z);

  assign expo_out = '{valid: expo_valid, sat: expo_sat, a: expo_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q    <= '0;
      expo_valid <= 1'b0;
    end else begin
      valid_q    <= {valid_q[1:0], valid_in};
      expo_valid <= valid_q[2];
    end
  end

  always_ff @(posedge clk) begin
    fx <= fold(x_index, cfg.size_x);
    fy <= fold(y_index, cfg.size_y);
    fz <= z_index;
    parts_q[0] <= parts_new;

    sq_x <= SQ_W'(fx) * SQ_W'(fx);
    sq_y <= SQ_W'(fy) * SQ_W'(fy);
    sq_z <= SQ_W'(fz) * SQ_W'(fz);
    parts_q[1] <= parts_q[0];

    prod_x <= PROD_W'(cfg.coef_x) * PROD_W'(sq_x);
    prod_y <= PROD_W'(cfg.coef_y) * PROD_W'(sq_y);
    prod_z <= PROD_W'(cfg.coef_z) * PROD_W'(sq_z);
    parts_q[2] <= parts_q[1];

    expo_sat  <= (sum >= EXP_LIMIT);
    expo_a    <= sum[EXPO_W-1:0];
    parts_out <= parts_q[2];
  end

endmodule

### hdl/gkf_gain.sv
module gkf_gain (
  input  logic            clk,
  input  logic            rst,
  input  gkf_pkg::expo_t  expo_in,
  input  gkf_pkg::parts_t parts_in,
  output gkf_pkg::gain_t  gain_out,
  output gkf_pkg::parts_t parts_out
);
  import gkf_pkg::*;

  localparam int GAIN_LAT = 5;
  localparam int INT_W    = EXPO_W - FRAC_W;
  localparam int SEG_W    = 8;
  localparam int PQ_W     = EXP_W + SEG_W;

  function automatic logic [EXP_W-1:0] mul_q30(input logic [EXP_W-1:0] x,
                                               input logic [EXP_W-1:0] y);
    logic [2*EXP_W-1:0] p;
    p = (2*EXP_W)'(x) * (2*EXP_W)'(y) + ((2*EXP_W)'(1) << (Q_FRAC - 1));
    return p[Q_FRAC+EXP_W-1:Q_FRAC];
  endfunction

  // exp(-a) = exp(-n) * exp(-f1/2^8) * exp(-f2/2^16) * (1 - f3/2^24), where
  // the last factor is linear because the square of f3/2^24 is far below one gain LSB.
  logic [EXP_W-1:0] tab_int [2**INT_W];
  logic [EXP_W-1:0] tab_hi  [2**SEG_W];
  logic [EXP_W-1:0] tab_mid [2**SEG_W];

  for (genvar g = 0; g < 2**INT_W; g++) begin : g_int
    localparam logic [EXP_W-1:0] V = exp_int_q30(g);
    assign tab_int[g] = V;
  end

  for (genvar g = 0; g < 2**SEG_W; g++) begin : g_seg
    localparam logic [EXP_W-1:0] VH = exp_frac_q30(64'(g) << (48 - SEG_W));
    localparam logic [EXP_W-1:0] VM = exp_frac_q30(64'(g) << (48 - 2*SEG_W));
    assign tab_hi[g]  = VH;
    assign tab_mid[g] = VM;
  end

  logic [INT_W-1:0] n_idx;
  logic [SEG_W-1:0] f1, f2, f3;

  assign n_idx = expo_in.a[EXPO_W-1:FRAC_W];
  assign f1    = expo_in.a[FRAC_W-1:FRAC_W-SEG_W];
  assign f2    = expo_in.a[FRAC_W-SEG_W-1:FRAC_W-2*SEG_W];
  assign f3    = expo_in.a[SEG_W-1:0];

  logic [GAIN_LAT-2:0] valid_q;
  logic [GAIN_LAT-2:0] sat_q;
  logic [EXP_W-1:0]    t_int, t_hi, t_mid1, t_mid2;
  logic [SEG_W-1:0]    f3_q [3];
  logic [EXP_W-1:0]    p1, p2, p2_q;
  logic [PQ_W-1:0]     q;
  parts_t              parts_q [GAIN_LAT-1];

  logic [PQ_W-1:0]  q_rnd;
  logic [EXP_W-1:0] g_lin;
  logic [EXP_W-1:0] g_rnd;

  logic              gain_valid;
  logic [GAIN_W-1:0] gain_val;

  assign gain_out = '{valid: gain_valid, gain: gain_val};

  always_comb begin
    q_rnd = q + (PQ_W'(1) << (FRAC_W - 1));
    g_lin = p2_q - EXP_W'(q_rnd[PQ_W-1:FRAC_W]);
    g_rnd = g_lin + (EXP_W'(1) << (GAIN_SH - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q    <= '0;
      gain_valid <= 1'b0;
    end else begin
      valid_q    <= {valid_q[GAIN_LAT-3:0], expo_in.valid};
      gain_valid <= valid_q[GAIN_LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    sat_q <= {sat_q[GAIN_LAT-3:0], expo_in.sat};

    t_int   <= tab_int[n_idx];
    t_hi    <= tab_hi[f1];
    t_mid1  <= tab_mid[f2];
    f3_q[0] <= f3;

    p1      <= mul_q30(t_int, t_hi);
    t_mid2  <= t_mid1;
    f3_q[1] <= f3_q[0];

    p2      <= mul_q30(p1, t_mid2);
    f3_q[2] <= f3_q[1];

    q    <= PQ_W'(p2) * PQ_W'(f3_q[2]);
    p2_q <= p2;

    gain_val <= sat_q[GAIN_LAT-2] ? '0 : g_rnd[EXP_W-1:GAIN_SH];

    parts_q[0] <= parts_in;
    for (int s = 1; s < GAIN_LAT - 1; s++) begin
      parts_q[s] <= parts_q[s-1];
    end
    parts_out <= parts_q[GAIN_LAT-2];
  end

  a_sat_zero: assert property (@(posedge clk) disable iff (rst)
      (expo_in.valid && expo_in.sat) |-> ##5 (gain_out.gain == '0))
    else $error("saturated exponent did not give zero gain");

  a_gain_max: assert property (@(posedge clk) disable iff (rst)
      gain_out.valid |-> (gain_out.gain <= GAIN_ONE))
    else $error("gain above unity");

endmodule

### hdl/gkf_scale.sv
module gkf_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  gkf_pkg::gain_t                    gain_in,
  input  gkf_pkg::parts_t                   parts_in,
  output logic                              done,
  output logic signed [gkf_pkg::DATA_W-1:0] re_out,
  output logic signed [gkf_pkg::DATA_W-1:0] im_out
);
  import gkf_pkg::*;

  localparam int M_W = DATA_W + GAIN_W;

  logic           valid_q;
  logic [M_W-1:0] m_re, m_im;
  logic           neg_re, neg_im;

  logic [M_W-1:0]    r_re, r_im;
  logic [DATA_W-1:0] mag_re, mag_im;

  // Rounding the magnitude gives round half away from zero.
  always_comb begin
    r_re   = m_re + (M_W'(1) << 15);
    r_im   = m_im + (M_W'(1) << 15);
    mag_re = r_re[DATA_W+15:16];
    mag_im = r_im[DATA_W+15:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_q <= gain_in.valid;
      done    <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    m_re   <= M_W'(parts_in.mag_re) * M_W'(gain_in.gain);
    m_im   <= M_W'(parts_in.mag_im) * M_W'(gain_in.gain);
    neg_re <= parts_in.neg_re;
    neg_im <= parts_in.neg_im;
    re_out <= neg_re ? -$signed(mag_re) : $signed(mag_re);
    im_out <= neg_im ? -$signed(mag_im) : $signed(mag_im);
  end

  a_zero_gain: assert property (@(posedge clk) disable iff (rst)
      (gain_in.valid && gain_in.gain == '0) |-> ##2 (re_out == '0 && im_out == '0))
    else $error("zero gain gave a nonzero result");

endmodule

### hdl/gaussian_kspace_filter_unit.sv
// Gaussian low-pass window for one coefficient of a 3D half-spectrum grid.
//
// Requests: drive x_index, y_index, z_index, re_in and im_in with start high;
// the request is taken at a rising edge where start is high and busy is low.
// busy is high only while rst is asserted, so one request can be taken on
// every clock cycle.
// Results: re_out and im_out are valid for exactly one cycle while done is
// high, in request order. The receiver cannot stall the block; a result must
// be captured in the cycle done is high.
// Registers: wr_en, wr_index and wr_data write size_x (0), size_y (1),
// coef_x (2), coef_y (3) and coef_z (4); other indexes are ignored. Write
// them only while no request is in flight.
// Pipeline: 4 stages fold, square, scale by the coefficients and sum the
// exponent; 5 stages look up exp(-a) in three tables and chain the products;
// 2 stages multiply both parts by the gain and round.
// Reset: rst clears the pipeline valid bits and loads the register defaults.
module gaussian_kspace_filter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [gkf_pkg::IDX_W-1:0]            x_index,
  input  logic [gkf_pkg::IDX_W-1:0]            y_index,
  input  logic [gkf_pkg::IDX_W-1:0]            z_index,
  input  logic signed [gkf_pkg::DATA_W-1:0]    re_in,
  input  logic signed [gkf_pkg::DATA_W-1:0]    im_in,
  output logic                                 done,
  output logic signed [gkf_pkg::DATA_W-1:0]    re_out,
  output logic signed [gkf_pkg::DATA_W-1:0]    im_out,
  input  logic                                 wr_en,
  input  logic [gkf_pkg::REG_IDX_W-1:0]        wr_index,
  input  logic [gkf_pkg::COEF_W-1:0]           wr_data
);
  import gkf_pkg::*;

  cfg_t   cfg;
  expo_t  expo;
  gain_t  gain;
  parts_t parts_e, parts_g;
  logic   accept;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x <= SIZE_RESET;
      cfg.size_y <= SIZE_RESET;
      cfg.coef_x <= '0;
      cfg.coef_y <= '0;
      cfg.coef_z <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SIZE_X: cfg.size_x <= wr_data[SIZE_W-1:0];
        REG_SIZE_Y: cfg.size_y <= wr_data[SIZE_W-1:0];
        REG_COEF_X: cfg.coef_x <= wr_data;
        REG_COEF_Y: cfg.coef_y <= wr_data;
        REG_COEF_Z: cfg.coef_z <= wr_data;
        default: ;
      endcase
    end
  end

  gkf_exponent u_exponent (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .valid_in  (accept),
    .x_index   (x_index),
    .y_index   (y_index),
    .z_index   (z_index),
    .re_in     (re_in),
    .im_in     (im_in),
    .expo_out  (expo),
    .parts_out (parts_e)
  );

  gkf_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .expo_in   (expo),
    .parts_in  (parts_e),
    .gain_out  (gain),
    .parts_out (parts_g)
  );

  gkf_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .gain_in  (gain),
    .parts_in (parts_g),
    .done     (done),
    .re_out   (re_out),
    .im_out   (im_out)
  );

  a_req_done: assert property (@(posedge clk) disable iff (rst)
      accept |-> ##11 done)
    else $error("request did not produce a result on time");

  a_done_req: assert property (@(posedge clk) disable iff (rst)
      done |-> $past(accept, 11))
    else $error("result strobe without a matching request");

endmodule

### bench/gaussian_window_checker.sv
`timescale 1ns / 1ps

module gaussian_window_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [gkf_pkg::IDX_W-1:0]         x_index,
  input  logic [gkf_pkg::IDX_W-1:0]         y_index,
  input  logic [gkf_pkg::IDX_W-1:0]         z_index,
  input  logic signed [gkf_pkg::DATA_W-1:0] re_in,
  input  logic signed [gkf_pkg::DATA_W-1:0] im_in,
  input  logic                              done,
  input  logic signed [gkf_pkg::DATA_W-1:0] re_out,
  input  logic signed [gkf_pkg::DATA_W-1:0] im_out,
  input  logic                              wr_en,
  input  logic [gkf_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [gkf_pkg::COEF_W-1:0]        wr_data,
  output int                                errors,
  output int                                pending
);
  import gkf_pkg::*;

  localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
  localparam logic [63:0] SAT_EXPO = 64'd12 << FRAC_W;

  // Every accepted value lies in one of three slots, one per gain within
  // the allowed LSB of the ideal gain.
  typedef struct packed {
    logic [2:0][DATA_W-1:0] re_ok;
    logic [2:0][DATA_W-1:0] im_ok;
  } windowed_coeff_t;

  windowed_coeff_t windowed_q[$];
  cfg_t            regs;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [63:0] fold_distance(input logic [IDX_W-1:0] idx,
                                                input logic [SIZE_W-1:0] size);
    logic [63:0] i;
    logic [63:0] s;
    i = 64'(idx);
    s = 64'(size);
    if (i <= (s >> 1)) return i;
    return (i >= s) ? i - s : s - i;
  endfunction

  // exp(-f) for f in [0, 1] in Q34.30, truncated alternating series.
  function automatic logic [63:0] decay_frac_q30(input logic [63:0] f);
    longint      acc;
    logic [63:0] term;
    acc  = longint'(UNIT_Q30);
    term = UNIT_Q30;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * f) >> 30) / 64'(k);
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    return 64'(acc);
  endfunction

  function automatic logic [GAIN_W-1:0] window_gain(input logic [63:0] expo);
    logic [63:0] v;
    logic [63:0] e1;
    logic [63:0] whole;
    if (expo >= SAT_EXPO) return '0;
    whole = expo >> FRAC_W;
    v     = decay_frac_q30((expo & 64'hFF_FFFF) << 6);
    e1    = decay_frac_q30(UNIT_Q30);
    for (int i = 0; i < 12; i++) begin
      if (64'(i) < whole) v = (v * e1 + (64'd1 << 29)) >> 30;
    end
    return GAIN_W'((v + 64'd8192) >> 14);
  endfunction

  // Magnitude times gain, rounded half away from zero.
  function automatic logic [DATA_W-1:0] scaled_part(input logic signed [DATA_W-1:0] raw,
                                                    input logic [GAIN_W-1:0] gain);
    longint      r;
    logic [63:0] mag;
    logic [63:0] m;
    r   = longint'(raw);
    mag = (r < 0) ? 64'(-r) : 64'(r);
    m   = (mag * 64'(gain) + 64'd32768) >> 16;
    return (r < 0) ? DATA_W'(64'd0 - m) : DATA_W'(m);
  endfunction

  function automatic windowed_coeff_t predict_windowed(
      input logic [IDX_W-1:0] xi, input logic [IDX_W-1:0] yi, input logic [IDX_W-1:0] zi,
      input logic signed [DATA_W-1:0] re, input logic signed [DATA_W-1:0] im);
    windowed_coeff_t    w;
    logic [63:0]        fx;
    logic [63:0]        fy;
    logic [63:0]        fz;
    logic [63:0]        expo;
    logic [GAIN_W-1:0]  g;
    logic [GAIN_W-1:0]  cand [3];
    logic               loose;
    fx   = fold_distance(xi, regs.size_x);
    fy   = fold_distance(yi, regs.size_y);
    fz   = 64'(zi);
    expo = 64'(regs.coef_x) * (fx * fx) + 64'(regs.coef_y) * (fy * fy)
         + 64'(regs.coef_z) * (fz * fz);
    g    = window_gain(expo);
    // Zero exponent and saturation give exact gains; elsewhere one LSB of slack.
    loose   = (expo != 0) && (expo < SAT_EXPO);
    cand[0] = (loose && g != 0) ? g - 1'b1 : g;
    cand[1] = g;
    cand[2] = (loose && g != GAIN_ONE) ? g + 1'b1 : g;
    for (int i = 0; i < 3; i++) begin
      w.re_ok[i] = scaled_part(re, cand[i]);
      w.im_ok[i] = scaled_part(im, cand[i]);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    windowed_coeff_t w;
    if (rst) begin
      regs.size_x = SIZE_RESET;
      regs.size_y = SIZE_RESET;
      regs.coef_x = '0;
      regs.coef_y = '0;
      regs.coef_z = '0;
      windowed_q.delete();
    end else begin
      if (done) begin
        if (windowed_q.size() == 0) begin
          report_mismatch($sformatf("result re=%0d im=%0d with no request outstanding",
                                    re_out, im_out));
        end else begin
          w = windowed_q.pop_front();
          if (re_out != w.re_ok[0] && re_out != w.re_ok[1] && re_out != w.re_ok[2])
            report_mismatch($sformatf("re_out %0d, expected %0d", re_out,
                                      $signed(w.re_ok[1])));
          if (im_out != w.im_ok[0] && im_out != w.im_ok[1] && im_out != w.im_ok[2])
            report_mismatch($sformatf("im_out %0d, expected %0d", im_out,
                                      $signed(w.im_ok[1])));
        end
      end
      if (start && !busy)
        windowed_q.push_back(predict_windowed(x_index, y_index, z_index, re_in, im_in));
      if (wr_en) begin
        case (wr_index)
          REG_SIZE_X: regs.size_x = wr_data[SIZE_W-1:0];
          REG_SIZE_Y: regs.size_y = wr_data[SIZE_W-1:0];
          REG_COEF_X: regs.coef_x = wr_data;
          REG_COEF_Y: regs.coef_y = wr_data;
          REG_COEF_Z: regs.coef_z = wr_data;
          default: ;
        endcase
      end
    end
    pending = windowed_q.size();
  end

endmodule

### bench/gaussian_kspace_filter_unit_test.sv
`timescale 1ns / 1ps

module gaussian_kspace_filter_unit_test;
  import gkf_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 190;

  typedef bit bool_gap_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [IDX_W-1:0]         x_index;
  logic [IDX_W-1:0]         y_index;
  logic [IDX_W-1:0]         z_index;
  logic signed [DATA_W-1:0] re_in;
  logic signed [DATA_W-1:0] im_in;
  logic                     done;
  logic signed [DATA_W-1:0] re_out;
  logic signed [DATA_W-1:0] im_out;
  logic                     wr_en;
  logic [REG_IDX_W-1:0]     wr_index;
  logic [COEF_W-1:0]        wr_data;
  int                       errors;
  int                       pending;

  gaussian_kspace_filter_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_index(x_index), .y_index(y_index), .z_index(z_index),
    .re_in(re_in), .im_in(im_in),
    .done(done), .re_out(re_out), .im_out(im_out),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  gaussian_window_checker window_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_index(x_index), .y_index(y_index), .z_index(z_index),
    .re_in(re_in), .im_in(im_in),
    .done(done), .re_out(re_out), .im_out(im_out),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL gaussian_kspace_filter_unit");
    $finish;
  end

  task automatic send_coeff(input logic [IDX_W-1:0] xi, input logic [IDX_W-1:0] yi,
                            input logic [IDX_W-1:0] zi, input logic [DATA_W-1:0] re,
                            input logic [DATA_W-1:0] im);
    @(negedge clk);
    start   <= 1'b1;
    x_index <= xi;
    y_index <= yi;
    z_index <= zi;
    re_in   <= re;
    im_in   <= im;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Registers may only change with no request in flight.
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_part();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return SIZE_W'(2);
      1: return SIZE_W'(1024);
      2: return SIZE_W'($urandom_range(0, 2047));
      default: return SIZE_W'(2 * $urandom_range(1, 512));
    endcase
  endfunction

  // Mostly inside the grid; some indices beyond it.
  function automatic logic [IDX_W-1:0] pick_index(input logic [SIZE_W-1:0] size);
    if (size == 0 || $urandom_range(0, 99) < 15) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, int'(size) - 1));
  endfunction

  // Coefficient that keeps the exponent term near the interesting range.
  function automatic logic [COEF_W-1:0] scaled_coef(input int span);
    longint cap;
    if (span < 1) span = 1;
    cap = (longint'(8) << FRAC_W) / (longint'(span) * span);
    return COEF_W'($urandom_range(0, int'(cap)));
  endfunction

  initial begin : stimulus
    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    int                z_hi;
    int                zr;
    bool_gap_t         gap_on;
    rst      <= 1'b1;
    start    <= 1'b0;
    x_index  <= '0;
    y_index  <= '0;
    z_index  <= '0;
    re_in    <= '0;
    im_in    <= '0;
    wr_en    <= 1'b0;
    wr_index <= '0;
    wr_data  <= '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset registers: unit gain everywhere, so data passes unchanged.
    send_coeff(10'd0, 10'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coeff(10'd1023, 10'd1023, 10'd512, 32'hFFFF_FFFF, 32'h0000_0001);
    send_coeff(10'd1, 10'd2, 10'd0, 32'h0000_0000, 32'h5555_AAAA);
    send_coeff(10'h2AA, 10'h155, 10'd511, 32'hAAAA_5555, 32'h8000_0001);
    drain();

    // Odd x size, tiny y size, and a z coefficient where z = 2 lands exactly on 12.0.
    write_reg(REG_SIZE_X, 32'd7);
    write_reg(REG_SIZE_Y, 32'd1);
    write_reg(REG_COEF_X, 32'd1 << FRAC_W);
    write_reg(REG_COEF_Y, 32'd1 << (FRAC_W - 2));
    write_reg(REG_COEF_Z, 32'd3 << FRAC_W);
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    send_coeff(10'd0, 10'd0, 10'd0, 32'h1234_5678, 32'hEDCB_A988);
    send_coeff(10'd1, 10'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coeff(10'd3, 10'd0, 10'd0, 32'h0000_0003, 32'hFFFF_FFFD);
    send_coeff(10'd4, 10'd0, 10'd0, 32'h4000_0000, 32'hC000_0000);
    send_coeff(10'd6, 10'd2, 10'd0, 32'h0001_0001, 32'hFFFE_FFFF);
    send_coeff(10'd7, 10'd1, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coeff(10'd1023, 10'd1023, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coeff(10'd3, 10'd4, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coeff(10'd0, 10'd0, 10'd1, 32'h0000_8000, 32'hFFFF_8000);
    send_coeff(10'd0, 10'd0, 10'd2, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coeff(10'd0, 10'd0, 10'd512, 32'h7FFF_FFFF, 32'h8000_0000);
    send_coeff(10'd2, 10'd3, 10'd1, 32'h0000_0001, 32'hFFFF_FFFF);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      sx = pick_size();
      sy = pick_size();
      zr = $urandom_range(0, 3);
      z_hi = (zr == 0) ? 1 : (zr == 1) ? 15 : (zr == 2) ? 100 : 512;
      write_reg(REG_SIZE_X, 32'(sx));
      write_reg(REG_SIZE_Y, 32'(sy));
      if (ph == 3) begin
        write_reg(REG_COEF_X, $urandom);
        write_reg(REG_COEF_Y, $urandom);
        write_reg(REG_COEF_Z, $urandom);
      end else if (ph == 7) begin
        // Everything saturates unless all three folded indices are zero.
        sx = SIZE_W'(2);
        sy = SIZE_W'(2);
        z_hi = 1;
        write_reg(REG_SIZE_X, 32'd2);
        write_reg(REG_SIZE_Y, 32'd2);
        write_reg(REG_COEF_X, 32'hFFFF_FFFF);
        write_reg(REG_COEF_Y, 32'hFFFF_FFFF);
        write_reg(REG_COEF_Z, 32'hFFFF_FFFF);
      end else if (ph == 5) begin
        write_reg(REG_COEF_X, 32'd0);
        write_reg(REG_COEF_Y, 32'd0);
        write_reg(REG_COEF_Z, 32'd0);
      end else begin
        write_reg(REG_COEF_X, scaled_coef(int'(sx) / 2));
        write_reg(REG_COEF_Y, scaled_coef(int'(sy) / 2));
        write_reg(REG_COEF_Z, scaled_coef(z_hi));
      end
      write_reg(REG_IDX_W'($urandom_range(5, 7)), $urandom);

      gap_on = (ph % 4 != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_coeff(pick_index(sx), pick_index(sy),
                   ($urandom_range(0, 99) < 80) ? IDX_W'($urandom_range(0, z_hi))
                                                : IDX_W'($urandom_range(0, 512)),
                   pick_part(), pick_part());
        if (gap_on) hold_off(pick_gap());
      end
      drain();
    end

    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS gaussian_kspace_filter_unit");
    end else begin
      $display("FAIL gaussian_kspace_filter_unit");
    end
    $finish;
  end

endmodule
